// ===== rtl/assert_macros.svh =====
// assertion helpers for the stack allocator
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define ASSERT_HOLDS(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// condition must never be seen outside reset
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`else

`define ASSERT_HOLDS(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

// ===== rtl/fisa_pkg.sv =====
`default_nettype none

package fisa_pkg;

    localparam int IDX_W          = 10;
    localparam int CNT_W          = 11;
    localparam int MODE_W         = 2;
    localparam int STATUS_W       = 2;
    localparam int POOL_DEPTH_DEF = 1024;
    localparam int SLOT_LIMIT_RST = 1024;

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [CNT_W-1:0] t_cnt;

    typedef enum logic [MODE_W-1:0] {
        MODE_OBTAIN      = 2'd0,
        MODE_RELEASE     = 2'd1,
        MODE_RELEASE_ALL = 2'd2
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_NONE_OUT = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_FILL,
        S_IDLE,
        S_EXEC,
        S_SWEEP
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/fisa_stack_mem.sv =====
`default_nettype none

module fisa_stack_mem #(
    parameter int DEPTH = fisa_pkg::POOL_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_we,
    input  wire logic [AW-1:0]          i_waddr,
    input  wire fisa_pkg::t_idx         i_wdata,
    input  wire logic                   i_re,
    input  wire logic [AW-1:0]          i_raddr,
    output fisa_pkg::t_idx              o_rdata
);
    import fisa_pkg::*;

    t_idx r_mem [DEPTH];
    t_idx r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/free_index_stack_allocator_core.sv =====
// a beat is captured in the idle state; its result enters the output register in the
// execute state once that register is free. As the stack read is registered, no new beat is
// taken until that load, nor while release-all sweeps the entries below the slot limit
// reset: synchronous, active low; afterwards a fill pass writes each stack
// entry i with i, and no input beat is taken until it ends (config writes are taken)
`default_nettype none

module free_index_stack_allocator_core #(
    parameter int POOL_DEPTH = fisa_pkg::POOL_DEPTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // configuration
    input  wire logic                          i_cfg_we,
    input  wire logic [fisa_pkg::CNT_W-1:0]    i_cfg_wdata,
    // request channel
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [fisa_pkg::MODE_W-1:0]   i_mode,
    input  wire logic [fisa_pkg::IDX_W-1:0]    i_release_index,
    // result channel
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [fisa_pkg::IDX_W-1:0]         o_granted_index,
    output logic [fisa_pkg::STATUS_W-1:0]      o_status,
    output logic [fisa_pkg::CNT_W-1:0]         o_in_use_count
);
    import fisa_pkg::*;

    `include "assert_macros.svh"

    // head must be able to hold the depth itself (all slots in use)
    localparam int HW = $clog2(POOL_DEPTH + 1);
    localparam int AW = $clog2(POOL_DEPTH);
    // common width for comparing the head against the slot limit
    localparam int CW = (HW > CNT_W) ? HW : CNT_W;
    localparam t_cnt PS_RST =
        CNT_W'((POOL_DEPTH < SLOT_LIMIT_RST) ? POOL_DEPTH : SLOT_LIMIT_RST);

    // control state
    t_state          r_state, n_state;
    logic [HW-1:0]   r_head, n_head;
    t_cnt            r_slot_limit;
    logic [HW-1:0]   r_sweep;
    logic [HW-1:0]   r_sweep_end;
    logic            r_out_valid;

    // captured request beat
    logic [MODE_W-1:0] r_mode;
    t_idx              r_rel;

    // output register
    t_idx            r_granted, n_granted;
    t_status         r_status, n_status;
    t_cnt            r_count;

    // stack memory port
    logic            mem_we, mem_re;
    logic [AW-1:0]   mem_waddr;
    t_idx            mem_wdata;
    t_idx            mem_rdata;

    logic            out_free;
    logic            out_load;
    logic            sweep_start;
    logic            sweep_last;
    logic            pool_empty;
    logic [CW-1:0]   cfg_ext;
    logic [CW-1:0]   cfg_clamped;

    fisa_stack_mem #(
        .DEPTH (POOL_DEPTH),
        .AW    (AW)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (r_head[AW-1:0]),
        .o_rdata (mem_rdata)
    );

    // the output register can take a new result when empty or drained this cycle
    assign out_free   = !r_out_valid || i_out_ready;
    assign sweep_last = ((r_sweep + 1'b1) == r_sweep_end);
    // obtain is refused once the head reaches the slot limit or the stack depth
    assign pool_empty = (CW'(r_head) >= CW'(r_slot_limit)) || (r_head >= HW'(POOL_DEPTH));

    // out-of-range slot limits: zero counts as one, above depth counts as depth
    assign cfg_ext = CW'(i_cfg_wdata);
    always_comb begin
        if (cfg_ext == '0) begin
            cfg_clamped = CW'(1);
        end else if (cfg_ext > CW'(POOL_DEPTH)) begin
            cfg_clamped = CW'(POOL_DEPTH);
        end else begin
            cfg_clamped = cfg_ext;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_FILL: begin
                if (sweep_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                if (out_free) begin
                    n_state = (r_mode == MODE_RELEASE_ALL) ? S_SWEEP : S_IDLE;
                end
            end
            S_SWEEP: begin
                if (sweep_last) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath control
    always_comb begin
        o_in_ready  = 1'b0;
        mem_re      = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = r_sweep[AW-1:0];
        mem_wdata   = t_idx'(r_sweep);
        n_head      = r_head;
        out_load    = 1'b0;
        n_granted   = '0;
        n_status    = ST_OK;
        sweep_start = 1'b0;
        unique case (r_state)
            S_FILL, S_SWEEP: begin
                // rewrite one entry with its own position each cycle
                mem_we = 1'b1;
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                // fetch the top of the free stack in case this beat is an obtain
                mem_re     = i_in_valid;
            end
            S_EXEC: begin
                if (out_free) begin
                    out_load = 1'b1;
                    unique case (r_mode)
                        MODE_OBTAIN: begin
                            if (pool_empty) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_granted = mem_rdata;
                                n_head    = r_head + 1'b1;
                            end
                        end
                        MODE_RELEASE: begin
                            if (r_head == '0) begin
                                // nothing outstanding: flag and leave the stack alone
                                n_status = ST_NONE_OUT;
                            end else begin
                                n_head    = r_head - 1'b1;
                                mem_we    = 1'b1;
                                mem_waddr = AW'(r_head - 1'b1);
                                mem_wdata = r_rel;
                            end
                        end
                        MODE_RELEASE_ALL: begin
                            n_head      = '0;
                            sweep_start = 1'b1;
                        end
                        default: begin
                            // unused mode: no operation
                        end
                    endcase
                end
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_FILL;
            r_head       <= '0;
            r_slot_limit <= PS_RST;
            r_sweep      <= '0;
            r_sweep_end  <= HW'(POOL_DEPTH);
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            if (i_cfg_we) begin
                r_slot_limit <= CNT_W'(cfg_clamped);
            end
            if (sweep_start) begin
                // size is latched so a late config write cannot move the end
                r_sweep     <= '0;
                r_sweep_end <= HW'(r_slot_limit);
            end else if (r_state == S_FILL || r_state == S_SWEEP) begin
                r_sweep <= r_sweep + 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_mode <= i_mode;
            r_rel  <= i_release_index;
        end
        if (out_load) begin
            r_granted <= n_granted;
            r_status  <= n_status;
            r_count   <= CNT_W'(n_head);
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_granted_index = r_granted;
    assign o_status        = r_status;
    assign o_in_use_count  = r_count;

    // head never passes the stack depth
    `ASSERT_HOLDS(a_head_bound, i_clk, i_rst_n, r_head <= HW'(POOL_DEPTH), "head beyond depth")
    // a read is never issued in the same cycle as a write, so no bypass is needed
    `ASSERT_NEVER(a_no_rw_overlap, i_clk, i_rst_n, mem_we && mem_re, "stack read and write overlap")
    // a fresh result only comes out of the execute step
    `ASSERT_HOLDS(a_result_src, i_clk, i_rst_n, $rose(r_out_valid) |-> $past(r_state) == S_EXEC, "result without execute")
    // a waiting result always reports the current head
    `ASSERT_HOLDS(a_count_head, i_clk, i_rst_n, r_out_valid |-> r_count == CNT_W'(r_head), "count differs from head")

endmodule

`default_nettype wire

// ===== bench/tb_free_index_stack_allocator_core.sv =====
`timescale 1ns / 1ps

module tb_free_index_stack_allocator_core;
    import fisa_pkg::*;

    localparam int DEPTH        = POOL_DEPTH_DEF;
    localparam int LIMIT_CYCLES = 500000;
    // the one mode code the block leaves unused
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    typedef struct {
        t_idx    granted;
        t_status status;
        t_cnt    in_use;
    } t_alloc_result;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    t_cnt               cfg_wdata = '0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [MODE_W-1:0]  req_mode = '0;
    t_idx               req_rel = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    t_idx               res_granted;
    logic [STATUS_W-1:0] res_status;
    t_cnt               res_in_use;

    // idling knobs, percent of cycles
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;

    // own copy of the allocator state
    t_idx        free_model[DEPTH];
    int unsigned head_model;
    int unsigned size_model;

    t_alloc_result pending_results[$];

    free_index_stack_allocator_core #(
        .POOL_DEPTH(DEPTH)
    ) dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_mode          (req_mode),
        .i_release_index (req_rel),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_granted_index (res_granted),
        .o_status        (res_status),
        .o_in_use_count  (res_in_use)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // run-away guard
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("tb_free_index_stack_allocator_core failed");
            $finish;
        end
    end

    function automatic void reset_model();
        int i;
        for (i = 0; i < DEPTH; i++) free_model[i] = t_idx'(i);
        head_model = 0;
        size_model = SLOT_LIMIT_RST;
    endfunction

    // zero counts as one slot, anything past the stack depth as the full depth
    function automatic int unsigned clamp_pool(t_cnt v);
        if (v == '0) return 1;
        if (v > DEPTH) return DEPTH;
        return 32'(v);
    endfunction

    // one step of the free stack: pop on obtain, push on release, refill on release-all
    function automatic t_alloc_result next_allocation(logic [MODE_W-1:0] mode, t_idx rel);
        t_alloc_result r;
        int i;
        r.granted = '0;
        r.status  = ST_OK;
        case (mode)
            MODE_OBTAIN: begin
                if (head_model >= size_model || head_model >= DEPTH) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.granted = free_model[head_model];
                    head_model++;
                end
            end
            MODE_RELEASE: begin
                if (head_model == 0) begin
                    r.status = ST_NONE_OUT;
                end else begin
                    head_model--;
                    free_model[head_model] = rel;
                end
            end
            MODE_RELEASE_ALL: begin
                // entries above the pool size keep their old contents
                for (i = 0; i < size_model; i++) free_model[i] = t_idx'(i);
                head_model = 0;
            end
            default: ;
        endcase
        r.in_use = t_cnt'(head_model);
        return r;
    endfunction

    // result side: random stall, then compare each accepted beat with the oldest prediction
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                error_count++;
                $display("%0t: result beat with none expected, actual granted %0d status %0d count %0d",
                         $time, res_granted, res_status, res_in_use);
            end else begin
                if (res_granted !== pending_results[0].granted) begin
                    error_count++;
                    $display("%0t: granted_index expected %0d actual %0d",
                             $time, pending_results[0].granted, res_granted);
                end
                if (res_status !== pending_results[0].status) begin
                    error_count++;
                    $display("%0t: status expected %0d actual %0d",
                             $time, pending_results[0].status, res_status);
                end
                if (res_in_use !== pending_results[0].in_use) begin
                    error_count++;
                    $display("%0t: in_use_count expected %0d actual %0d",
                             $time, pending_results[0].in_use, res_in_use);
                end
                void'(pending_results.pop_front());
            end
        end
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // one request beat; valid is only dropped for a gap, never between back-to-back beats
    task automatic send_req(input logic [MODE_W-1:0] mode, input t_idx rel);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        req_mode <= mode;
        req_rel  <= rel;
        do @(posedge clk); while (!in_ready);
        pending_results.push_back(next_allocation(mode, rel));
    endtask

    task automatic hold_until_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    // pool size write, only once the block has gone quiet (sweep finished too)
    task automatic write_pool(input t_cnt v);
        hold_until_drained();
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        size_model = clamp_pool(v);
    endtask

    function automatic t_idx pick_index();
        int unsigned p;
        p = $urandom_range(9);
        if (p == 0) return '0;
        if (p == 1) return '1;
        return t_idx'($urandom);
    endfunction

    // mostly small pools so release-all sweeps stay short
    function automatic t_cnt pick_pool();
        int unsigned p;
        p = $urandom_range(11);
        case (p)
            0:       return '0;
            1:       return t_cnt'(1);
            2:       return t_cnt'($urandom_range(DEPTH + 1, 2047));
            3:       return t_cnt'(DEPTH);
            default: return t_cnt'($urandom_range(2, 40));
        endcase
    endfunction

    task automatic test_after_reset();
        // reset stack holds 0,1,2,... from the bottom
        send_req(MODE_OBTAIN, '1);
        send_req(MODE_OBTAIN, '0);
        send_req(MODE_OBTAIN, t_idx'($urandom));
        send_req(MODE_RELEASE, '1);
        send_req(MODE_OBTAIN, '0);
        send_req(MODE_UNUSED, '1);
        send_req(MODE_RELEASE_ALL, t_idx'($urandom));
        // release with nothing outstanding is flagged
        send_req(MODE_RELEASE, t_idx'(5));
        send_req(MODE_UNUSED, '0);
        send_req(MODE_OBTAIN, '0);
    endtask

    task automatic test_pool_clamp();
        write_pool(t_cnt'(1));
        send_req(MODE_RELEASE_ALL, '0);
        send_req(MODE_OBTAIN, '0);
        send_req(MODE_OBTAIN, '0);
        // zero behaves as a single slot
        write_pool('0);
        send_req(MODE_RELEASE_ALL, '1);
        send_req(MODE_OBTAIN, '0);
        send_req(MODE_OBTAIN, '0);
        // above the depth behaves as the full depth
        write_pool('1);
        send_req(MODE_RELEASE_ALL, '0);
    endtask

    task automatic test_shrink_and_stale();
        int i;
        write_pool(t_cnt'(4));
        send_req(MODE_RELEASE_ALL, '0);
        for (i = 0; i < 5; i++) send_req(MODE_OBTAIN, '0);
        // shrink while four slots are out: obtains refused, stack left alone
        write_pool(t_cnt'(2));
        send_req(MODE_OBTAIN, '0);
        send_req(MODE_RELEASE, '1);
        send_req(MODE_RELEASE, '0);
        send_req(MODE_RELEASE, t_idx'(700));
        send_req(MODE_RELEASE, t_idx'(333));
        // refill only covers the two bottom entries
        send_req(MODE_RELEASE_ALL, '0);
        write_pool(t_cnt'(4));
        for (i = 0; i < 4; i++) send_req(MODE_OBTAIN, '0);
    endtask

    task automatic test_full_pool();
        int i;
        write_pool(t_cnt'(DEPTH));
        send_req(MODE_RELEASE_ALL, '0);
        for (i = 0; i <= DEPTH; i++) send_req(MODE_OBTAIN, t_idx'($urandom));
        send_req(MODE_RELEASE, '1);
        send_req(MODE_OBTAIN, '0);
        send_req(MODE_RELEASE_ALL, '0);
    endtask

    task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned stall_pct);
        int seg;
        int n;
        int unsigned p;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (seg = 0; seg < 3; seg++) begin
            write_pool(pick_pool());
            for (n = 0; n < 24; n++) begin
                p = $urandom_range(99);
                if (p < 47)
                    send_req(MODE_OBTAIN, t_idx'($urandom));
                else if (p < 90)
                    send_req(MODE_RELEASE, pick_index());
                else if (p < 95)
                    send_req(MODE_RELEASE_ALL, t_idx'($urandom));
                else
                    send_req(MODE_UNUSED, t_idx'($urandom));
            end
            // sender holds off until every result is back
            hold_until_drained();
        end
    endtask

    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        reset_model();
        test_after_reset();
        test_pool_clamp();
        test_shrink_and_stale();
        test_full_pool();
        test_random_traffic(0, 0);
        test_random_traffic(59, 0);
        test_random_traffic(0, 59);
        test_random_traffic(28, 28);
        hold_until_drained();
        recv_stall_pct = 0;
        repeat (20) @(posedge clk);
        if (error_count == 0) begin
            $display("tb_free_index_stack_allocator_core passed");
        end else begin
            $display("tb_free_index_stack_allocator_core failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/fisa_pkg.sv
rtl/fisa_stack_mem.sv
rtl/free_index_stack_allocator_core.sv
bench/tb_free_index_stack_allocator_core.sv
